FILE: hdl/wefm_pkg.sv
// ----------------------------------------------------------------------------
// wefm_pkg
// Shared types and constants of the wheel encoder fault monitor.
// ----------------------------------------------------------------------------
package wefm_pkg;

	// Geometry
	localparam int WHEEL_COUNT    = 4;
	localparam int SPEED_BITS     = 16;
	localparam int WHEEL_IDX_BITS = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
	localparam int TIME_BITS      = 32;
	localparam int CFG_BITS       = 16;
	localparam int STILL_BITS     = 15;
	localparam int CFG_IDX_BITS   = 2;
	localparam int QUEUE_DEPTH    = 2;

	// Input kinds
	localparam logic [1:0] KIND_ENC   = 2'd0;
	localparam logic [1:0] KIND_DRV   = 2'd1;
	localparam logic [1:0] KIND_CHECK = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// Decoded operations handed to the back end
	localparam logic [1:0] OP_NOP   = 2'd0;
	localparam logic [1:0] OP_ENC   = 2'd1;
	localparam logic [1:0] OP_DRV   = 2'd2;
	localparam logic [1:0] OP_CHECK = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ENC_STALE = 2'd1;
	localparam logic [1:0] ST_ENC_FAIL  = 2'd2;
	localparam logic [1:0] ST_DRV_STALE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_STALE   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GAP     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PERSIST = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STILL   = 2'd3;

	// Register reset values
	localparam logic [CFG_BITS-1:0]   RST_STALE   = 16'd110;
	localparam logic [CFG_BITS-1:0]   RST_GAP     = 16'd128;
	localparam logic [CFG_BITS-1:0]   RST_PERSIST = 16'd500;
	localparam logic [STILL_BITS-1:0] RST_STILL   = 15'd3;

	typedef logic signed [SPEED_BITS-1:0] speed_t;
	typedef speed_t [WHEEL_COUNT-1:0] speed_vec_t;

	// Input beat
	typedef struct packed {
		logic [1:0]           kind;
		logic [TIME_BITS-1:0] time_ms;
		speed_t               speed_w0;
		speed_t               speed_w1;
		speed_t               speed_w2;
		speed_t               speed_w3;
	} in_t;

	// Result beat
	typedef struct packed {
		logic       checked;
		logic       healthy;
		logic [1:0] status;
		logic       fault_latched;
		logic [1:0] failed_wheel;
	} out_t;

	// Classified item travelling from front to back
	typedef struct packed {
		logic [1:0]           op;
		logic [TIME_BITS-1:0] time_ms;
		speed_vec_t           speed;
	} cmd_t;

endpackage

FILE: hdl/wefm_front.sv
// ----------------------------------------------------------------------------
// wefm_front
// Accepts input beats, decodes the kind into an operation and holds the
// classified item until the queue takes it.
// ----------------------------------------------------------------------------
module wefm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wefm_pkg::in_t     in_data,
	output logic              push_valid,
	input  logic              push_ready,
	output wefm_pkg::cmd_t    push_data
);

	logic           valid_s1;
	wefm_pkg::cmd_t cmd_s1;
	wefm_pkg::cmd_t cmd_d;

	// Stage is free when empty or when its beat moves on this cycle
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = cmd_s1;

	// Classify the incoming beat
	always_comb begin
		cmd_d.time_ms  = in_data.time_ms;
		cmd_d.speed[0] = in_data.speed_w0;
		cmd_d.speed[1] = in_data.speed_w1;
		cmd_d.speed[2] = in_data.speed_w2;
		cmd_d.speed[3] = in_data.speed_w3;
		unique case (in_data.kind)
			wefm_pkg::KIND_ENC:   cmd_d.op = wefm_pkg::OP_ENC;
			wefm_pkg::KIND_DRV:   cmd_d.op = wefm_pkg::OP_DRV;
			wefm_pkg::KIND_CHECK: cmd_d.op = wefm_pkg::OP_CHECK;
			wefm_pkg::KIND_NONE:  cmd_d.op = wefm_pkg::OP_NOP;
			default:              cmd_d.op = wefm_pkg::OP_NOP;
		endcase
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

FILE: hdl/wefm_queue.sv
// ----------------------------------------------------------------------------
// wefm_queue
// Short FIFO between the front and the back end so each side stalls alone.
// ----------------------------------------------------------------------------
module wefm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  wefm_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output wefm_pkg::cmd_t pop_data
);

	localparam int PTR_BITS = (wefm_pkg::QUEUE_DEPTH > 1) ? $clog2(wefm_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(wefm_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(wefm_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(wefm_pkg::QUEUE_DEPTH);

	wefm_pkg::cmd_t              slot_q [wefm_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0]         wr_ptr_q;
	logic [PTR_BITS-1:0]         rd_ptr_q;
	logic [CNT_BITS-1:0]         count_q;
	logic                        push;
	logic                        pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a lone push");

endmodule

FILE: hdl/wefm_back.sv
// ----------------------------------------------------------------------------
// wefm_back
// Holds the stored speeds, stamps and fault state, runs the health check and
// drives the result register. Per-wheel errors are refreshed on each store so
// a check only searches them.
// ----------------------------------------------------------------------------
module wefm_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  wefm_pkg::cmd_t                       pop_data,
	input  logic                                 cfg_we,
	input  logic [wefm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [wefm_pkg::CFG_BITS-1:0]        cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output wefm_pkg::out_t                       out_data
);

	localparam int WC = wefm_pkg::WHEEL_COUNT;
	localparam int SB = wefm_pkg::SPEED_BITS;
	localparam int IB = wefm_pkg::WHEEL_IDX_BITS;
	localparam int TB = wefm_pkg::TIME_BITS;

	// Configuration
	logic [wefm_pkg::CFG_BITS-1:0]   stale_q;
	logic [wefm_pkg::CFG_BITS-1:0]   gap_q;
	logic [wefm_pkg::CFG_BITS-1:0]   persist_q;
	logic [wefm_pkg::STILL_BITS-1:0] still_q;

	// Stored state
	wefm_pkg::speed_vec_t meas_q;
	wefm_pkg::speed_vec_t cmd_q;
	logic [SB-1:0]        err_q [WC];
	logic [TB-1:0]        enc_stamp_q;
	logic [TB-1:0]        drv_stamp_q;
	logic                 have_enc_q;
	logic                 have_drv_q;
	logic [TB-1:0]        clear_time_q;
	logic                 fault_q;
	logic [1:0]           fault_wheel_q;

	// Result register
	logic                 out_valid_q;
	wefm_pkg::out_t       res_q;

	// Combinational results
	logic                 take;
	logic [SB-1:0]        err_d [WC];
	logic [IB-1:0]        cand;
	logic [SB-1:0]        best;
	logic [SB-1:0]        second;
	logic                 enc_stale;
	logic                 drv_stale;
	logic                 suspect;
	logic                 persist_over;
	logic                 fail;
	logic                 clear_upd;
	logic                 healthy_d;
	logic [1:0]           status_d;

	assign take      = pop_valid && pop_ready;
	assign pop_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	// Fresh per-wheel error magnitudes for a store beat
	always_comb begin
		logic signed [SB:0] diff;
		logic signed [SB:0] mag;
		for (int i = 0; i < WC; i++) begin
			if (pop_data.op == wefm_pkg::OP_ENC) begin
				diff = {pop_data.speed[i][SB-1], pop_data.speed[i]} - {cmd_q[i][SB-1], cmd_q[i]};
			end else begin
				diff = {meas_q[i][SB-1], meas_q[i]} - {pop_data.speed[i][SB-1], pop_data.speed[i]};
			end
			mag      = diff[SB] ? -diff : diff;
			err_d[i] = mag[SB-1:0];
		end
	end

	// Largest error, lowest index on ties, then largest of the rest
	always_comb begin
		best = err_q[0];
		cand = '0;
		for (int i = 1; i < WC; i++) begin
			if (err_q[i] > best) begin
				best = err_q[i];
				cand = IB'(i);
			end
		end
		second = '0;
		for (int i = 0; i < WC; i++) begin
			if (IB'(i) != cand && err_q[i] > second) begin
				second = err_q[i];
			end
		end
	end

	// Health check decision
	always_comb begin
		enc_stale    = !have_enc_q ||
			((pop_data.time_ms - enc_stamp_q) > {{(TB-wefm_pkg::CFG_BITS){1'b0}}, stale_q});
		drv_stale    = !have_drv_q ||
			((pop_data.time_ms - drv_stamp_q) > {{(TB-wefm_pkg::CFG_BITS){1'b0}}, stale_q});
		suspect      = (meas_q[cand] <= $signed({1'b0, still_q})) &&
			((best - second) >= gap_q);
		persist_over = (enc_stamp_q - clear_time_q) >
			{{(TB-wefm_pkg::CFG_BITS){1'b0}}, persist_q};
		fail         = 1'b0;
		clear_upd    = 1'b0;
		healthy_d    = 1'b0;
		status_d     = wefm_pkg::ST_OK;
		if (pop_data.op == wefm_pkg::OP_CHECK) begin
			priority if (enc_stale) begin
				status_d = wefm_pkg::ST_ENC_STALE;
			end else if (drv_stale) begin
				healthy_d = 1'b1;
				status_d  = wefm_pkg::ST_DRV_STALE;
			end else begin
				fail      = suspect && persist_over;
				clear_upd = !suspect;
				healthy_d = !fail;
				status_d  = fail ? wefm_pkg::ST_ENC_FAIL : wefm_pkg::ST_OK;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q   <= wefm_pkg::RST_STALE;
			gap_q     <= wefm_pkg::RST_GAP;
			persist_q <= wefm_pkg::RST_PERSIST;
			still_q   <= wefm_pkg::RST_STILL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wefm_pkg::CFG_STALE:   stale_q   <= cfg_data;
				wefm_pkg::CFG_GAP:     gap_q     <= cfg_data;
				wefm_pkg::CFG_PERSIST: persist_q <= cfg_data;
				wefm_pkg::CFG_STILL:   still_q   <= cfg_data[wefm_pkg::STILL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Monitor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q        <= '0;
			cmd_q         <= '0;
			for (int i = 0; i < WC; i++) begin
				err_q[i] <= '0;
			end
			enc_stamp_q   <= '0;
			drv_stamp_q   <= '0;
			have_enc_q    <= 1'b0;
			have_drv_q    <= 1'b0;
			clear_time_q  <= '0;
			fault_q       <= 1'b0;
			fault_wheel_q <= '0;
		end else if (take) begin
			unique case (pop_data.op)
				wefm_pkg::OP_ENC: begin
					meas_q      <= pop_data.speed;
					err_q       <= err_d;
					enc_stamp_q <= pop_data.time_ms;
					have_enc_q  <= 1'b1;
				end
				wefm_pkg::OP_DRV: begin
					cmd_q       <= pop_data.speed;
					err_q       <= err_d;
					drv_stamp_q <= pop_data.time_ms;
					have_drv_q  <= 1'b1;
				end
				wefm_pkg::OP_CHECK: begin
					if (clear_upd) begin
						clear_time_q <= enc_stamp_q;
					end
					if (fail) begin
						fault_q       <= 1'b1;
						fault_wheel_q <= 2'(cand);
					end
				end
				wefm_pkg::OP_NOP: ;
				default: ;
			endcase
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	// Result payload; the fault fields show the state after this beat
	always_ff @(posedge clk) begin
		if (take) begin
			res_q.checked       <= (pop_data.op == wefm_pkg::OP_CHECK);
			res_q.healthy       <= healthy_d;
			res_q.status        <= status_d;
			res_q.fault_latched <= fault_q || fail;
			res_q.failed_wheel  <= fail ? 2'(cand) : fault_wheel_q;
		end
	end

	// Checks
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("fault latch dropped");
	a_fail_latched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status == wefm_pkg::ST_ENC_FAIL |->
			res_q.fault_latched && !res_q.healthy && res_q.checked)
		else $error("failure result without latched fault");
	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.checked |-> !res_q.healthy && res_q.status == wefm_pkg::ST_OK)
		else $error("non-check result carries a check answer");

endmodule

FILE: hdl/wheel_encoder_fault_monitor.sv
// Path: an accepted input beat passes the front register, then the queue,
// then the back end's result register, which presents its result.
// Throughput: one item per cycle while out_ready is high; the back end's check over
// pre-registered wheel errors sets the rate, the two-entry queue absorbs stalls.
// Reset: arst_n clears all stored speeds, stamps and the fault latch at once
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// wheel_encoder_fault_monitor
// Top level: front classifier, decoupling queue and check back end.
// ----------------------------------------------------------------------------
module wheel_encoder_fault_monitor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  wefm_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output wefm_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wefm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [wefm_pkg::CFG_BITS-1:0]     cfg_data
);

	logic           push_valid;
	logic           push_ready;
	wefm_pkg::cmd_t push_data;
	logic           pop_valid;
	logic           pop_ready;
	wefm_pkg::cmd_t pop_data;

	// Register writes are always accepted; cfg_ready is tied high
	assign cfg_ready = 1'b1;

	wefm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	wefm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	wefm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
